>>> design/ckme_pkg.sv
package ckme_pkg;

   // Line store geometry and image size limits.
   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_HEIGHT = 1024;
   localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
   localparam int unsigned SIZE_W     = 11;
   localparam int unsigned PIX_W      = 32;

   // Result queue depth (power of two).
   localparam int unsigned RQ_DEPTH   = 8;
   localparam int unsigned RQ_PTR_W   = $clog2(RQ_DEPTH);
   localparam int unsigned RQ_CNT_W   = $clog2(RQ_DEPTH + 1);

   // Configuration register indexes.
   localparam logic [1:0] CSR_COLOR_KEY    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);

   // Result transaction as it sits in the output queue.
   typedef struct packed {
      logic             last_of_run;
      logic             solid;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } result_type;

   // Pixel in flight between the line store read and the write back.
   typedef struct packed {
      logic [COL_W-1:0] x;
      logic [ROW_W-1:0] y;
      logic             cur;
      logic             has_up;
      logic             last_row;
      logic             bit_ok;
   } pixel_type;

   // Saturate a written size to 1..limit.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] limit);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > limit) begin
         r = limit;
      end
      return r;
   endfunction

endpackage

>>> design/colorkey_mask_erosion_top.sv
// Color-key mask erosion with a 3x3 cross element, streamed in raster order.
// Input channel req_*: one pixel per transaction, tdata = pixel value, tuser =
// frame start. A pixel is solid when it differs from the color key. The pixel
// at row y produces the mask bit of (col, y-1); in the last row it also
// produces the zero mask bit of its own position, with tlast set only on the
// final result of each pixel.
// Output channel rsp_*: tdata = {solid, row, col}, tlast = last result of run.
// Configuration port csr_*: write color key, width and height between images.
// Throughput: one pixel per clock in all rows but the last while the receiver
// keeps taking results; the last row emits two results per pixel and runs
// slower, set by the single-result output port. A result is registered in stage
// one and then in the result queue before it is offered. Two line stores live in
// one 2-bit wide memory read at x and x+1 and written at x, one write per pixel.
// Reset clears the position counters and the result queue and loads the
// default registers (key 0, 1024 x 1024). The line store holds no reset.
// When the receiver stalls, results wait in an eight-entry queue; req_tready
// drops only when that queue cannot take the results of pixels in flight.
module colorkey_mask_erosion_top (
   input  logic        clock,
   input  logic        reset,
   // Pixel input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_value
   input  logic        req_tuser,   // [0] frame_start
   // Mask result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] col, [19:10] row, [20] solid, zero pad
   output logic        rsp_tlast,   // last_of_run
   // Configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned COL_W  = ckme_pkg::COL_W;
   localparam int unsigned ROW_W  = ckme_pkg::ROW_W;
   localparam int unsigned SIZE_W = ckme_pkg::SIZE_W;
   localparam int unsigned PTR_W  = ckme_pkg::RQ_PTR_W;
   localparam int unsigned CNT_W  = ckme_pkg::RQ_CNT_W;

   // Configuration registers.
   logic [ckme_pkg::PIX_W-1:0] color_key_ff, color_key_in;
   logic [SIZE_W-1:0]          width_ff, width_in;
   logic [SIZE_W-1:0]          height_ff, height_in;

   always_comb begin
      color_key_in = color_key_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            ckme_pkg::CSR_COLOR_KEY:    color_key_in = csr_wdata;
            ckme_pkg::CSR_IMAGE_WIDTH:
               width_in = ckme_pkg::clamp_size(csr_wdata[SIZE_W-1:0], ckme_pkg::MAX_W_SIZE);
            ckme_pkg::CSR_IMAGE_HEIGHT:
               height_in = ckme_pkg::clamp_size(csr_wdata[SIZE_W-1:0], ckme_pkg::MAX_H_SIZE);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_key_ff <= '0;
         width_ff     <= ckme_pkg::MAX_W_SIZE;
         height_ff    <= ckme_pkg::MAX_H_SIZE;
      end else begin
         color_key_ff <= color_key_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   // Position of the incoming pixel, with wrap and frame start applied.
   logic              accept;
   logic [SIZE_W-1:0] col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0]  row_cnt_ff, row_cnt_in;
   logic [SIZE_W-1:0] cc, rc;
   logic [COL_W-1:0]  x0, x0_next;
   logic [ROW_W-1:0]  y0;
   ckme_pkg::pixel_type px0;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      cc = req_tuser ? '0 : col_cnt_ff;
      rc = req_tuser ? '0 : SIZE_W'(row_cnt_ff);
      if (cc >= width_ff) begin
         cc = '0;
         rc = rc + SIZE_W'(1);
      end
      if (rc >= height_ff) begin
         rc = '0;
      end
      x0      = cc[COL_W-1:0];
      y0      = rc[ROW_W-1:0];
      x0_next = x0 + COL_W'(1);

      px0.x        = x0;
      px0.y        = y0;
      px0.cur      = (req_tdata != color_key_ff);
      px0.has_up   = (y0 != '0);
      px0.last_row = (rc == height_ff - SIZE_W'(1));
      px0.bit_ok   = (y0 > ROW_W'(1)) && (x0 != '0) &&
                     ((SIZE_W'(x0) + SIZE_W'(1)) < width_ff);

      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         col_cnt_in = cc + SIZE_W'(1);
         row_cnt_in = y0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // Line store: bit 1 holds the row before last, bit 0 the previous row.
   logic [1:0] line_mem [ckme_pkg::MAX_WIDTH];
   logic [1:0] rd_a_ff;
   logic       rd_b_ff;

   // Stage one: pixel whose line store data is now available.
   logic                s1_valid_ff, s1_valid_in;
   ckme_pkg::pixel_type s1_ff;
   logic [1:0]          wr_data;
   logic                fwd_a_ff, fwd_a_in;
   logic                fwd_b_ff, fwd_b_in;
   logic [1:0]          fwd_a_data_ff;
   logic                fwd_b_data_ff;

   // The write of the pixel in stage one lands at the same edge as the next
   // read, so a read of that entry takes the write data instead.
   assign fwd_a_in    = s1_valid_ff && (s1_ff.x == x0);
   assign fwd_b_in    = s1_valid_ff && (s1_ff.x == x0_next);
   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      rd_a_ff       <= line_mem[x0];
      rd_b_ff       <= line_mem[x0_next][0];
      fwd_a_data_ff <= wr_data;
      fwd_b_data_ff <= wr_data[0];
      if (s1_valid_ff) begin
         line_mem[s1_ff.x] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= px0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_a_ff    <= 1'b0;
         fwd_b_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_a_ff    <= fwd_a_in;
         fwd_b_ff    <= fwd_b_in;
      end
   end

   // Neighborhood of (x, y-1) and the mask bit.
   logic [1:0] entry_a;
   logic       center, up, right, mask_bit;
   logic       left_ff, left_in;

   assign entry_a  = fwd_a_ff ? fwd_a_data_ff : rd_a_ff;
   assign center   = entry_a[0];
   assign up       = entry_a[1];
   assign right    = fwd_b_ff ? fwd_b_data_ff : rd_b_ff;
   assign mask_bit = s1_ff.bit_ok && center && left_ff && right && up && s1_ff.cur;
   assign wr_data  = {center, s1_ff.cur};
   // The left neighbor is the previous-row bit read for the pixel just before.
   assign left_in  = s1_valid_ff ? center : left_ff;

   always_ff @(posedge clock) begin
      left_ff <= left_in;
   end

   // Results of the stage one pixel.
   ckme_pkg::result_type res0, res1;
   logic [1:0]           push_n;

   always_comb begin
      res1.col         = s1_ff.x;
      res1.row         = s1_ff.y;
      res1.solid       = 1'b0;
      res1.last_of_run = 1'b1;
      if (s1_ff.has_up) begin
         res0.col         = s1_ff.x;
         res0.row         = s1_ff.y - ROW_W'(1);
         res0.solid       = mask_bit;
         res0.last_of_run = !s1_ff.last_row;
      end else begin
         res0 = res1;
      end
      push_n = s1_valid_ff ? (2'(s1_ff.has_up) + 2'(s1_ff.last_row)) : 2'd0;
   end

   // Result queue.
   ckme_pkg::result_type rq_mem [ckme_pkg::RQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_ptr_1;
   ckme_pkg::result_type rsp_res;

   assign wr_ptr_1 = wr_ptr_ff + PTR_W'(1);
   assign pop      = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         rq_mem[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         rq_mem[wr_ptr_1] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Room for two results of stage one and two of the new pixel.
   assign req_tready = ((CNT_W + 1)'(count_ff) + (s1_valid_ff ? (CNT_W + 1)'(2) : '0)
                        + (CNT_W + 1)'(2)) <= (CNT_W + 1)'(ckme_pkg::RQ_DEPTH);

   assign rsp_res    = rq_mem[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {3'b000, rsp_res.solid, rsp_res.row, rsp_res.col};
   assign rsp_tlast  = rsp_res.last_of_run;

endmodule

>>> design/ckme_checker.sv
module ckme_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // The result queue is empty right after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result stays offered and unchanged.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // The first result of a last-row pixel is followed at once by its partner
   // at the same column.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp_tlast && !rsp_tdata[20] &&
          (rsp_tdata[9:0] == $past(rsp_tdata[9:0]))))
      else $error("second result of a run missing or misplaced");

   // A set mask bit never lies on the top row or the left column.
   a_no_border_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[20]) |->
         ((rsp_tdata[9:0] != 10'd0) && (rsp_tdata[19:10] != 10'd0)))
      else $error("mask bit set on the image border");

endmodule

bind colorkey_mask_erosion_top ckme_checker u_ckme_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/tb_colorkey_mask_erosion_top.sv
module tb_colorkey_mask_erosion_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PIX_W      = ckme_pkg::PIX_W;
   localparam int unsigned SIZE_W     = ckme_pkg::SIZE_W;
   localparam int unsigned COL_W      = ckme_pkg::COL_W;
   localparam int unsigned ROW_W      = ckme_pkg::ROW_W;
   localparam int unsigned MAX_WIDTH  = ckme_pkg::MAX_WIDTH;
   localparam int unsigned MAX_HEIGHT = ckme_pkg::MAX_HEIGHT;

   // Tracks the erosion mask the block should produce. It holds its own copy of
   // the registers, the raster position and both line stores.
   class mask_scoreboard;
      bit [PIX_W-1:0]  color_key;
      bit [SIZE_W-1:0] width_reg;
      bit [SIZE_W-1:0] height_reg;
      int unsigned     col_pos;
      int unsigned     row_pos;
      bit              upper_row [MAX_WIDTH];
      bit              older_row [MAX_WIDTH];
      bit              upper_known [MAX_WIDTH];
      bit              older_known [MAX_WIDTH];
      ckme_pkg::result_type pending_mask_bits [$];
      int unsigned     mismatches;

      function new();
         color_key  = '0;
         width_reg  = ckme_pkg::MAX_W_SIZE;
         height_reg = ckme_pkg::MAX_H_SIZE;
         col_pos    = 0;
         row_pos    = 0;
         mismatches = 0;
         foreach (upper_row[i]) begin
            upper_row[i]   = 1'b0;
            older_row[i]   = 1'b0;
            upper_known[i] = 1'b0;
            older_known[i] = 1'b0;
         end
      endfunction

      // Sizes saturate to 1..limit, with zero counting as one.
      function int unsigned eff_size(bit [SIZE_W-1:0] v, int unsigned limit);
         if (v == 0) return 1;
         if (v > limit) return limit;
         return v;
      endfunction

      function int unsigned cur_width();
         return eff_size(width_reg, MAX_WIDTH);
      endfunction

      function int unsigned cur_height();
         return eff_size(height_reg, MAX_HEIGHT);
      endfunction

      // True when both line stores have been written in every column below w.
      function bit stores_known(int unsigned w);
         for (int unsigned c = 0; c < w; c++) begin
            if (!(upper_known[c] && older_known[c])) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void write_register(logic [1:0] idx, logic [31:0] data);
         case (idx)
            ckme_pkg::CSR_COLOR_KEY:    color_key  = data;
            ckme_pkg::CSR_IMAGE_WIDTH:  width_reg  = data[SIZE_W-1:0];
            ckme_pkg::CSR_IMAGE_HEIGHT: height_reg = data[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      // Advances the raster position for one accepted pixel and queues the mask
      // bits that it completes.
      function void predict_mask_bits(bit [PIX_W-1:0] pix, bit start);
         int unsigned w, h, x, y;
         bit cur, centre, left, right, up;
         ckme_pkg::result_type r;
         w = cur_width();
         h = cur_height();
         if (start) begin
            col_pos = 0;
            row_pos = 0;
         end
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         x = col_pos;
         y = row_pos;
         cur    = (pix != color_key);
         centre = upper_row[x];
         up     = older_row[x];
         left   = (x > 0) ? older_row[x-1] : 1'b0;
         right  = (x + 1 < w) ? upper_row[x+1] : 1'b0;

         // Mask bit of the pixel one row up; border pixels are always clear.
         if (y > 0) begin
            r.col         = COL_W'(x);
            r.row         = ROW_W'(y - 1);
            r.solid       = (y > 1 && x > 0 && x + 1 < w) ?
                            (centre & left & right & up & cur) : 1'b0;
            r.last_of_run = (y != h - 1);
            pending_mask_bits.push_back(r);
         end
         // The last row also closes out its own, always clear, mask bit.
         if (y == h - 1) begin
            r.col         = COL_W'(x);
            r.row         = ROW_W'(y);
            r.solid       = 1'b0;
            r.last_of_run = 1'b1;
            pending_mask_bits.push_back(r);
         end

         older_row[x]   = upper_row[x];
         older_known[x] = upper_known[x];
         upper_row[x]   = cur;
         upper_known[x] = 1'b1;
         col_pos        = x + 1;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      // Compares one accepted result transaction with the oldest expected bit.
      task check_mask_bit(logic [23:0] data, logic last);
         ckme_pkg::result_type want;
         if (pending_mask_bits.size() == 0) begin
            report_mismatch($sformatf("unexpected result col %0d row %0d",
                                      data[COL_W-1:0], data[COL_W +: ROW_W]));
            return;
         end
         want = pending_mask_bits.pop_front();
         if (data[COL_W-1:0] !== want.col)
            report_mismatch($sformatf("col %0d, expected %0d", data[COL_W-1:0], want.col));
         if (data[COL_W +: ROW_W] !== want.row)
            report_mismatch($sformatf("row %0d, expected %0d at col %0d",
                                      data[COL_W +: ROW_W], want.row, want.col));
         if (data[COL_W+ROW_W] !== want.solid)
            report_mismatch($sformatf("solid %b, expected %b at col %0d row %0d",
                                      data[COL_W+ROW_W], want.solid, want.col, want.row));
         if (data[23:COL_W+ROW_W+1] !== '0)
            report_mismatch($sformatf("padding bits %b at col %0d row %0d",
                                      data[23:COL_W+ROW_W+1], want.col, want.row));
         if (last !== want.last_of_run)
            report_mismatch($sformatf("tlast %b, expected %b at col %0d row %0d",
                                      last, want.last_of_run, want.col, want.row));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [31:0] csr_wdata;

   mask_scoreboard sb;
   int unsigned    pixels_sent;
   int unsigned    sender_idle_pct;
   int unsigned    receiver_idle_pct;

   colorkey_mask_erosion_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #8ms;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: sample at the rising edge, change ready at the falling edge.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_mask_bit(rsp_tdata, rsp_tlast);
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   function automatic void set_idle_mode(int unsigned mode);
      case (mode)
         0: begin
            sender_idle_pct   = 37;
            receiver_idle_pct = 69;
         end
         1: begin
            sender_idle_pct   = 69;
            receiver_idle_pct = 37;
         end
         default: begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
      endcase
   endfunction

   // All driving tasks start and end at a falling edge.
   task automatic send_pixel(input logic [31:0] pix, input logic start);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pix;
      req_tuser  = start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.predict_mask_bits(pix, start);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Holds the input back until every expected result has arrived, then gives
   // pixels that produce no result time to clear the pipeline.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending_mask_bits.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = data;
      sb.write_register(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Mostly solid pixels so that interior mask bits come out set.
   function automatic logic [31:0] draw_pixel(int unsigned solid_pct);
      logic [31:0] v;
      if ($urandom_range(99) >= solid_pct) return sb.color_key;
      if ($urandom_range(3) == 0) v = sb.color_key ^ (32'h1 << $urandom_range(31));
      else v = $urandom();
      if (v == sb.color_key) v = v ^ 32'h1;
      return v;
   endfunction

   function automatic logic [31:0] draw_key();
      case ($urandom_range(3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Size words sometimes carry junk above the 11 register bits.
   function automatic logic [31:0] size_word(input int unsigned v);
      if ($urandom_range(3) == 0) return ($urandom() & 32'hFFFF_F800) | v;
      return v;
   endfunction

   task automatic send_image(input int unsigned count, input bit with_start,
                             input int unsigned solid_pct);
      for (int unsigned i = 0; i < count; i++) begin
         send_pixel(draw_pixel(solid_pct), with_start && i == 0);
      end
   endtask

   task automatic setup_small_image();
      if ($urandom_range(2) == 0) write_csr(ckme_pkg::CSR_COLOR_KEY, draw_key());
      write_csr(ckme_pkg::CSR_IMAGE_WIDTH,
                size_word($urandom_range(1, ($urandom_range(4) == 0) ? 40 : 12)));
      write_csr(ckme_pkg::CSR_IMAGE_HEIGHT, size_word($urandom_range(1, 8)));
   endtask

   // Mostly whole images with random content; the rest cut images short, run on
   // without a frame start, or resize in the middle of an image.
   task automatic run_random_images(input int unsigned target);
      int unsigned base, area, new_w, pick, solid_pct;
      base = pixels_sent;
      while (pixels_sent - base < target) begin
         set_idle_mode(((pixels_sent - base) * 3) / target);
         pick      = $urandom_range(99);
         solid_pct = ($urandom_range(3) == 0) ? 50 : 88;
         area      = sb.cur_width() * sb.cur_height();
         if (pick < 65) begin
            if ($urandom_range(1) == 1) begin
               wait_drained();
               setup_small_image();
            end
            send_image(sb.cur_width() * sb.cur_height(), 1'b1, solid_pct);
         end else if (pick < 77) begin
            send_image($urandom_range(1, area), 1'b1, solid_pct);
         end else if (pick < 87) begin
            send_image($urandom_range(1, 2 * area), 1'b0, solid_pct);
         end else begin
            send_image($urandom_range(1, area), ($urandom_range(1) == 1), solid_pct);
            wait_drained();
            // A new width is only taken where both line stores are filled.
            new_w = $urandom_range(1, 16);
            if (sb.stores_known(new_w)) write_csr(ckme_pkg::CSR_IMAGE_WIDTH, size_word(new_w));
            write_csr(ckme_pkg::CSR_IMAGE_HEIGHT, size_word($urandom_range(1, 8)));
            send_image($urandom_range(1, 2 * sb.cur_width() * sb.cur_height()), 1'b0,
                       solid_pct);
         end
      end
   endtask

   initial begin
      sb          = new();
      pixels_sent = 0;
      set_idle_mode(0);
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = ckme_pkg::CSR_COLOR_KEY;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Smallest image with an interior pixel, all solid: only the center is set.
      write_csr(ckme_pkg::CSR_COLOR_KEY, 32'hFFFF_FFFF);
      write_csr(ckme_pkg::CSR_IMAGE_WIDTH, 32'hFFFF_F803);
      write_csr(ckme_pkg::CSR_IMAGE_HEIGHT, 32'd3);
      for (int i = 0; i < 9; i++) send_pixel(32'h0000_0000, i == 0);

      // A hole above (1,1) clears it, while (2,1) keeps a full cross.
      wait_drained();
      write_csr(ckme_pkg::CSR_COLOR_KEY, 32'h0000_0000);
      write_csr(ckme_pkg::CSR_IMAGE_WIDTH, 32'd4);
      for (int i = 0; i < 12; i++) send_pixel((i == 1) ? 32'h0 : (32'h1 << (i * 3)), i == 0);

      // Zero height saturates to a single row: every pixel is its own last row.
      wait_drained();
      write_csr(ckme_pkg::CSR_IMAGE_WIDTH, 32'd2);
      write_csr(ckme_pkg::CSR_IMAGE_HEIGHT, 32'd0);
      send_pixel(32'h0000_0000, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b0);

      // Widest row, with an oversized width that saturates.
      wait_drained();
      set_idle_mode(1);
      write_csr(ckme_pkg::CSR_COLOR_KEY, draw_key());
      write_csr(ckme_pkg::CSR_IMAGE_WIDTH, 32'd2047);
      write_csr(ckme_pkg::CSR_IMAGE_HEIGHT, 32'd1);
      send_image(MAX_WIDTH, 1'b1, 60);

      // Tallest column, one pixel per row.
      wait_drained();
      set_idle_mode(2);
      write_csr(ckme_pkg::CSR_IMAGE_WIDTH, 32'd1);
      write_csr(ckme_pkg::CSR_IMAGE_HEIGHT, 32'd1024);
      send_image(MAX_HEIGHT, 1'b1, 60);

      wait_drained();
      run_random_images(400);

      // Let the last results come back, then give the verdict.
      req_tvalid = 1'b0;
      while (sb.pending_mask_bits.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
